@@ rtl/core/blwd_pkg.sv @@
// package for the bounded list with delete by value
// holds sizes, operation and status codes, and the command struct sent to the cell row
// no dependencies
package blwd_pkg;

    localparam int DEPTH = 16;
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = 32;
    localparam int PW = 4;
    localparam int RCW = 5;

    typedef enum logic [2:0] {
        FN_INS_FRONT = 3'd0,
        FN_DEL_FRONT = 3'd1,
        FN_DEL_BACK  = 3'd2,
        FN_DEL_AFTER = 3'd3,
        FN_DEL_VALUE = 3'd4,
        FN_CLEAR     = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic                 go;
        logic                 ins;
        logic                 del;
        logic                 by_val;
        logic signed [VW-1:0] key;
        logic [IW-1:0]        target;
        logic [CW-1:0]        count;
    } t_cell_cmd;

endpackage

@@ rtl/core/blwd_if.sv @@
// valid/ready channel interfaces for the list: request items and result items
// depends on nothing but the field widths of the list
interface blwd_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [3:0]         position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink (input valid, input func, input value, input position, output ready);
endinterface

interface blwd_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         removed_count;

    modport source (output valid, output status, output removed_value, output removed_count,
                    input ready);
    modport sink (input valid, input status, input removed_value, input removed_count,
                  output ready);
endinterface

@@ rtl/core/bounded_list_with_delete_by_value.sv @@
// top level of the bounded list: operation decode, entry count, result register
// depends on blwd_pkg, blwd_if and blwd_cell
//
//  channel   dir   modport  payload
//  i_in      in    sink     func, value, position
//  o_out     out   source   status, removed_value, removed_count
//
// the cell row shifts and compares all slots at once
// and a new item is taken each cycle the result register is free or being drained
// the search for a value ripples combinationally through the row of DEPTH cells
// reset clears the entry count and the result valid flag; slot values need no reset
// a stall on o_out holds the result and stops i_in until it is taken
module bounded_list_with_delete_by_value (
    input  logic i_clk,
    input  logic i_rst_n,
    blwd_req_if.sink   i_in,
    blwd_rsp_if.source o_out
);
    import blwd_pkg::*;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_valid;
    t_status              r_status;
    t_status              n_status;
    logic signed [VW-1:0] r_rval;
    logic signed [VW-1:0] n_rval;
    logic [RCW-1:0]       r_rcnt;
    logic [RCW-1:0]       n_rcnt;

    logic                 accept;
    t_func                func;
    t_cell_cmd            cmd;
    logic                 pos_ok;
    logic [CW+PW:0]       pos_next;
    logic [CW+RCW-1:0]    cnt_ext;

    logic signed [VW-1:0] w_val  [DEPTH];
    logic                 w_seen [DEPTH+1];
    logic signed [VW-1:0] w_rval [DEPTH+1];

    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign func       = t_func'(i_in.func);
    assign pos_next   = (CW+PW+1)'(i_in.position) + (CW+PW+1)'(1);
    assign pos_ok     = pos_next < (CW+PW+1)'(r_count);
    assign cnt_ext    = (CW+RCW)'(r_count);

    always_comb begin
        cmd        = '0;
        cmd.go     = accept;
        cmd.key    = i_in.value;
        cmd.count  = r_count;
        cmd.target = '0;
        case (func)
            FN_INS_FRONT: cmd.ins = (r_count != CW'(DEPTH));
            FN_DEL_FRONT: begin
                cmd.del    = (r_count != '0);
                cmd.target = '0;
            end
            FN_DEL_BACK: begin
                cmd.del    = (r_count != '0);
                cmd.target = IW'(r_count - CW'(1));
            end
            FN_DEL_AFTER: begin
                cmd.del    = pos_ok;
                cmd.target = IW'(pos_next);
            end
            FN_DEL_VALUE: begin
                cmd.del    = 1'b1;
                cmd.by_val = 1'b1;
            end
            default: ;
        endcase
    end

    assign w_seen[0] = 1'b0;
    assign w_rval[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        blwd_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_idx       (IW'(g)),
            .i_left_val  ((g == 0) ? i_in.value : w_val[(g == 0) ? 0 : g-1]),
            .i_right_val (w_val[(g == DEPTH-1) ? g : g+1]),
            .i_seen      (w_seen[g]),
            .i_rval      (w_rval[g]),
            .o_val       (w_val[g]),
            .o_seen      (w_seen[g+1]),
            .o_rval      (w_rval[g+1])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_rval   = '0;
        n_rcnt   = '0;
        case (func)
            FN_INS_FRONT: begin
                if (cmd.ins) begin
                    n_count = r_count + CW'(1);
                end else begin
                    n_status = ST_FULL;
                end
            end
            FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AFTER, FN_DEL_VALUE: begin
                if (cmd.del && w_seen[DEPTH]) begin
                    n_count = r_count - CW'(1);
                    n_rval  = w_rval[DEPTH];
                    n_rcnt  = RCW'(1);
                end else begin
                    n_status = ST_MISS;
                end
            end
            FN_CLEAR: begin
                n_count = '0;
                n_rcnt  = cnt_ext[RCW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_status <= n_status;
            r_rval   <= n_rval;
            r_rcnt   <= n_rcnt;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.status        = r_status;
    assign o_out.removed_value = r_rval;
    assign o_out.removed_count = r_rcnt;

endmodule

@@ rtl/core/blwd_cell.sv @@
// one slot of the list: holds a value, matches it, shifts from its neighbors
// depends on blwd_pkg
module blwd_cell (
    input  logic                          i_clk,
    input  blwd_pkg::t_cell_cmd           i_cmd,
    input  logic [blwd_pkg::IW-1:0]       i_idx,
    input  logic signed [blwd_pkg::VW-1:0] i_left_val,
    input  logic signed [blwd_pkg::VW-1:0] i_right_val,
    input  logic                          i_seen,
    input  logic signed [blwd_pkg::VW-1:0] i_rval,
    output logic signed [blwd_pkg::VW-1:0] o_val,
    output logic                          o_seen,
    output logic signed [blwd_pkg::VW-1:0] o_rval
);
    import blwd_pkg::*;

    logic signed [VW-1:0] r_val;
    logic signed [VW-1:0] n_val;
    logic                 live;
    logic                 hit;
    logic                 first;

    assign live   = CW'(i_idx) < i_cmd.count;
    assign hit    = i_cmd.by_val ? (live && (r_val == i_cmd.key)) : (i_idx == i_cmd.target);
    assign first  = hit && !i_seen;
    assign o_seen = i_seen || hit;
    assign o_rval = first ? (i_rval | r_val) : i_rval;
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (i_cmd.go && i_cmd.ins) begin
            n_val = (i_idx == '0) ? i_cmd.key : i_left_val;
        end else if (i_cmd.go && i_cmd.del && o_seen) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule
